// ----- hdl/sps_pkg.sv -----
// Package for the stepper position sequencer: opcodes, register indexes,
// reset values and the coil phase table. No dependencies.
`default_nettype none

package sps_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned PHASE_COUNT_DEF   = 8;
  localparam int unsigned PHASE_BITS        = 3;
  localparam int unsigned FIELD_POS_BITS    = 16;
  localparam int unsigned COIL_BITS         = 4;
  localparam int unsigned CFG_IDX_BITS      = 3;
  localparam int unsigned CFG_DATA_BITS     = 8;

  localparam logic [7:0] HOLD_LENGTH_RST = 8'd20;
  localparam logic [7:0] SLOW_RELOAD_RST = 8'd29;
  localparam logic [7:0] FAST_RELOAD_RST = 8'd2;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_TARGET = 3'd1,
    OP_SET_POS    = 3'd2,
    OP_STOP       = 3'd3,
    OP_REARM_HOLD = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    REG_MOTOR_KIND  = 3'd0,
    REG_SPEED_MODE  = 3'd1,
    REG_HOLD_LENGTH = 3'd2,
    REG_SLOW_RELOAD = 3'd3,
    REG_FAST_RELOAD = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SPEED_EVERY = 2'd0,
    SPEED_SLOW  = 2'd1,
    SPEED_FAST  = 2'd2
  } speed_e;

  typedef enum logic [1:0] {
    KIND_GAS_VALVE  = 2'd0,
    KIND_ICE_DOOR   = 2'd1,
    KIND_HOT        = 2'd2,
    KIND_NO_DECODER = 2'd3
  } kind_e;

  // Coil pattern for a motor kind and phase. The door motor runs full steps,
  // the other two run half steps.
  function automatic logic [COIL_BITS-1:0] coil_lookup(input logic [1:0] kind,
                                                       input logic [PHASE_BITS-1:0] phase);
    logic [COIL_BITS-1:0] half_tab [8];
    logic [COIL_BITS-1:0] full_tab [8];
    half_tab = '{4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};
    full_tab = '{4'hC, 4'h9, 4'h3, 4'h6, 4'hC, 4'h9, 4'h3, 4'h6};
    if (kind == KIND_ICE_DOOR) begin
      return full_tab[phase];
    end
    return half_tab[phase];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sps_if.sv -----
// Channel interfaces of the stepper position sequencer: command words,
// result words and configuration writes. Depends on sps_pkg.
`default_nettype none

interface sps_cmd_if
  import sps_pkg::*;
  ();
  logic                             valid;
  logic                             ready;
  logic [2:0]                       opcode;
  logic signed [FIELD_POS_BITS-1:0] position_value;

  modport source (output valid, output opcode, output position_value, input ready);
  modport sink   (input valid, input opcode, input position_value, output ready);
endinterface

interface sps_res_if
  import sps_pkg::*;
  ();
  logic                             valid;
  logic                             ready;
  logic [COIL_BITS-1:0]             coil_pattern;
  logic signed [FIELD_POS_BITS-1:0] position_now;
  logic                             at_target;

  modport source (output valid, output coil_pattern, output position_now,
                  output at_target, input ready);
  modport sink   (input valid, input coil_pattern, input position_now,
                  input at_target, output ready);
endinterface

interface sps_cfg_if
  import sps_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- hdl/stepper_position_sequencer_top.sv -----
// Top level of the stepper position sequencer: command decode, prescaler,
// hold counters, phase stepping and the result register. Depends on sps_pkg
// and sps_if.
// The result word for a command is registered and valid in the cycle after it is taken.
// Throughput: one command word per cycle; the only limit is the single result
// register, which is refilled in the cycle it is drained.
// Reset: all motion state clears, coils off, registers take their defaults.
`default_nettype none

module stepper_position_sequencer_top
  import sps_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned PHASE_COUNT   = PHASE_COUNT_DEF
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  sps_cmd_if.sink   cmd_i,
  sps_cfg_if.sink   cfg_i,
  sps_res_if.source res_o
);

  // Configuration registers. Writes are always taken; the host must write only
  // while the channel is idle, which the block itself does not enforce.
  logic [1:0] motor_kind_q, speed_mode_q;
  logic [7:0] hold_length_q, slow_reload_q, fast_reload_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_kind_q  <= KIND_GAS_VALVE;
      speed_mode_q  <= SPEED_EVERY;
      hold_length_q <= HOLD_LENGTH_RST;
      slow_reload_q <= SLOW_RELOAD_RST;
      fast_reload_q <= FAST_RELOAD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.reg_index))
        REG_MOTOR_KIND:  motor_kind_q  <= cfg_i.wdata[1:0];
        REG_SPEED_MODE:  speed_mode_q  <= cfg_i.wdata[1:0];
        REG_HOLD_LENGTH: hold_length_q <= cfg_i.wdata;
        REG_SLOW_RELOAD: slow_reload_q <= cfg_i.wdata;
        REG_FAST_RELOAD: fast_reload_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Motion state.
  logic [POSITION_BITS-1:0] target_q, target_d;
  logic [POSITION_BITS-1:0] cur_q, cur_d;
  logic [POSITION_BITS-1:0] rem_q, rem_d;
  logic [7:0]               pre_q, pre_d;
  logic [7:0]               start_hold_q, start_hold_d;
  logic [7:0]               stop_hold_q, stop_hold_d;
  logic [PHASE_BITS-1:0]    phase_q, phase_d;
  logic [COIL_BITS-1:0]     coil_q, coil_d;

  // Result register. A new command is taken whenever the result register is
  // empty or is being drained in the same cycle, so words flow back to back.
  logic                     res_valid_q;
  logic                     cmd_acc;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  logic [POSITION_BITS-1:0] operand;
  assign operand = POSITION_BITS'(cmd_i.position_value);

  always_comb begin
    logic                  period;
    logic                  drive_en;
    logic                  drive_on;
    logic [PHASE_BITS:0]   phase_up;
    target_d     = target_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    pre_d        = pre_q;
    start_hold_d = start_hold_q;
    stop_hold_d  = stop_hold_q;
    phase_d      = phase_q;
    coil_d       = coil_q;
    period       = 1'b0;
    drive_en     = 1'b0;
    drive_on     = 1'b0;
    phase_up     = {1'b0, phase_q} + 1'b1;

    case (opcode_e'(cmd_i.opcode))
      OP_TICK: begin
        // A new move starts only once the previous one has run out.
        if (rem_q == '0 && target_q != cur_q) begin
          rem_d        = target_q - cur_q;
          start_hold_d = hold_length_q;
          stop_hold_d  = hold_length_q;
        end
        period = 1'b1;
        if (speed_mode_q == SPEED_SLOW || speed_mode_q == SPEED_FAST) begin
          if (pre_q != '0) begin
            pre_d  = pre_q - 8'd1;
            period = 1'b0;
          end else begin
            pre_d = (speed_mode_q == SPEED_SLOW) ? slow_reload_q : fast_reload_q;
          end
        end
        if (period) begin
          drive_en = 1'b1;
          drive_on = 1'b1;
          if (start_hold_d != '0) begin
            start_hold_d = start_hold_d - 8'd1;
          end else if (rem_d == '0) begin
            if (stop_hold_d != '0) begin
              stop_hold_d = stop_hold_d - 8'd1;
            end else begin
              drive_on = 1'b0;
            end
          end else if (!rem_d[POSITION_BITS-1]) begin
            rem_d   = rem_d - 1'b1;
            cur_d   = cur_q + 1'b1;
            phase_d = (phase_up >= (PHASE_BITS+1)'(PHASE_COUNT)) ? '0
                                                                 : phase_up[PHASE_BITS-1:0];
          end else begin
            rem_d   = rem_d + 1'b1;
            cur_d   = cur_q - 1'b1;
            phase_d = (phase_q == '0) ? PHASE_BITS'(PHASE_COUNT - 1) : phase_q - 1'b1;
          end
        end
      end
      OP_SET_TARGET: target_d = operand;
      OP_SET_POS:    cur_d    = operand;
      OP_STOP: begin
        target_d     = cur_q;
        rem_d        = '0;
        start_hold_d = hold_length_q;
        stop_hold_d  = hold_length_q;
      end
      OP_REARM_HOLD: begin
        start_hold_d = hold_length_q;
        stop_hold_d  = hold_length_q;
      end
      default: ;
    endcase

    // The spare motor kind has no decoder, so the coil latch keeps its value.
    if (drive_en && motor_kind_q != KIND_NO_DECODER) begin
      coil_d = drive_on ? coil_lookup(motor_kind_q, phase_d) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      cur_q        <= '0;
      rem_q        <= '0;
      pre_q        <= '0;
      start_hold_q <= '0;
      stop_hold_q  <= '0;
      phase_q      <= '0;
      coil_q       <= '0;
    end else if (cmd_acc) begin
      target_q     <= target_d;
      cur_q        <= cur_d;
      rem_q        <= rem_d;
      pre_q        <= pre_d;
      start_hold_q <= start_hold_d;
      stop_hold_q  <= stop_hold_d;
      phase_q      <= phase_d;
      coil_q       <= coil_d;
    end
  end

  // Result word, captured from the updated state.
  logic [COIL_BITS-1:0]      res_coil_q;
  logic [FIELD_POS_BITS-1:0] res_pos_q;
  logic                      res_at_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_acc) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      res_coil_q <= coil_d;
      res_pos_q  <= FIELD_POS_BITS'(cur_d);
      res_at_q   <= (cur_d == target_d);
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.coil_pattern = res_coil_q;
  assign res_o.position_now = res_pos_q;
  assign res_o.at_target    = res_at_q;

endmodule

`default_nettype wire

// ----- hdl/sps_checker.sv -----
// Port-level checks for the stepper position sequencer, bound to the top
// level. Depends on stepper_position_sequencer_top and sps_pkg.
`default_nettype none

module sps_checker
  import sps_pkg::*;
(
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      cmd_valid_i,
  input wire                      cmd_ready_i,
  input wire                      res_valid_i,
  input wire                      res_ready_i,
  input wire [COIL_BITS-1:0]      res_coil_i,
  input wire [FIELD_POS_BITS-1:0] res_pos_i
);

  // Every taken command word yields a result word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> res_valid_i)
    else $error("no result word after a taken command");

  // A command is never taken while a result word is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |-> !cmd_ready_i)
    else $error("command taken over a stalled result word");

  // A stalled result word stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> ($stable(res_coil_i) && $stable(res_pos_i)))
    else $error("result word changed while stalled");

endmodule

bind stepper_position_sequencer_top sps_checker u_sps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_coil_i  (res_o.coil_pattern),
  .res_pos_i   (res_o.position_now)
);

`default_nettype wire

// ----- tb/tb_stepper_position_sequencer_top.sv -----
// Self-checking testbench for stepper_position_sequencer_top: random and directed command
// words checked against an in-bench model of the position sequencer.
// Depends on sps_pkg, the sps_if interfaces and the top level RTL.
`timescale 1ns / 1ps

module tb_stepper_position_sequencer_top
  import sps_pkg::*;
();

  // Opcodes above OP_REARM_HOLD are decoded as no-ops by the block.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  // Speed code that the package leaves unnamed.
  localparam logic [1:0] SPEED_SPARE     = 2'd3;

  // Coil sequences, phase 0 in the low nibble. The half-step sequence serves the gas
  // valve and the hot motor, the full-step sequence serves the door motor.
  localparam logic [31:0] HALF_STEP_COILS = {4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [31:0] FULL_STEP_COILS = {4'h6, 4'h3, 4'h9, 4'hC, 4'h6, 4'h3, 4'h9, 4'hC};
  localparam logic [2:0]  LAST_PHASE      = 3'd7;

  typedef struct packed {
    logic [3:0]  coils;
    logic [15:0] position;
    logic        at_target;
  } motor_status_t;

  logic clk_i;
  logic rst_ni;

  sps_cmd_if cmd_bus ();
  sps_cfg_if cfg_bus ();
  sps_res_if res_bus ();

  stepper_position_sequencer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .cfg_i  (cfg_bus),
    .res_o  (res_bus)
  );

  // Shadow copy of the configuration registers, updated on each accepted write.
  logic [1:0] kind_q;
  logic [1:0] speed_q;
  logic [7:0] hold_len_q;
  logic [7:0] slow_reload_q;
  logic [7:0] fast_reload_q;

  // Motion state of the channel as the bench sees it.
  logic [15:0] tgt_pos;
  logic [15:0] cur_pos;
  logic [15:0] steps_left;
  logic [7:0]  prescale;
  logic [7:0]  start_hold;
  logic [7:0]  stop_hold;
  logic [2:0]  phase;
  logic [3:0]  coils;

  motor_status_t expected_status[$];

  int  fail_count;
  int  words_sent;
  int  words_checked;
  int  settings_applied;
  bit  no_gaps;

  // Both sides draw their idle time per word here; no_gaps forces back-to-back traffic.
  function automatic int pick_gap();
    return no_gaps ? 0 : $urandom_range(0, 9);
  endfunction

  // ---------------------------------------------------------------------------
  // Motion model
  // ---------------------------------------------------------------------------

  // Latch the coil pattern for the current phase, or switch the coils off. A motor kind
  // without a decoder leaves the latch alone while the rest of the state still moves.
  task automatic drive_coils(input bit energize);
    logic [31:0] seq;
    if (kind_q == KIND_NO_DECODER) begin
      return;
    end
    seq = (kind_q == KIND_ICE_DOOR) ? FULL_STEP_COILS : HALF_STEP_COILS;
    coils = energize ? seq[phase*4 +: 4] : 4'h0;
  endtask

  // One step period: start hold first, then the move itself, then stop hold, then off.
  task automatic run_step_period();
    if (start_hold != 8'd0) begin
      start_hold = start_hold - 8'd1;
      drive_coils(1'b1);
    end else if (steps_left == 16'd0) begin
      if (stop_hold != 8'd0) begin
        stop_hold = stop_hold - 8'd1;
        drive_coils(1'b1);
      end else begin
        drive_coils(1'b0);
      end
    end else if (!steps_left[15]) begin
      steps_left = steps_left - 16'd1;
      cur_pos    = cur_pos + 16'd1;
      phase      = (phase == LAST_PHASE) ? 3'd0 : phase + 3'd1;
      drive_coils(1'b1);
    end else begin
      steps_left = steps_left + 16'd1;
      cur_pos    = cur_pos - 16'd1;
      phase      = (phase == 3'd0) ? LAST_PHASE : phase - 3'd1;
      drive_coils(1'b1);
    end
  endtask

  // A tick first picks up a new move if none is pending, then lets the prescaler decide
  // whether this tick is a step period. Speed modes every and spare skip the prescaler.
  task automatic run_tick();
    if (steps_left == 16'd0 && tgt_pos != cur_pos) begin
      steps_left = tgt_pos - cur_pos;
      start_hold = hold_len_q;
      stop_hold  = hold_len_q;
    end
    if (speed_q == SPEED_SLOW || speed_q == SPEED_FAST) begin
      if (prescale != 8'd0) begin
        prescale = prescale - 8'd1;
        return;
      end
      prescale = (speed_q == SPEED_SLOW) ? slow_reload_q : fast_reload_q;
    end
    run_step_period();
  endtask

  // Apply one accepted command word and queue the status word it must produce.
  task automatic predict_status(input logic [2:0] op, input logic [15:0] value);
    motor_status_t status;
    case (op)
      OP_TICK:       run_tick();
      OP_SET_TARGET: tgt_pos = value;
      OP_SET_POS:    cur_pos = value;
      OP_STOP: begin
        tgt_pos    = cur_pos;
        steps_left = 16'd0;
        start_hold = hold_len_q;
        stop_hold  = hold_len_q;
      end
      OP_REARM_HOLD: begin
        start_hold = hold_len_q;
        stop_hold  = hold_len_q;
      end
      default: ;
    endcase
    status.coils     = coils;
    status.position  = cur_pos;
    status.at_target = (cur_pos == tgt_pos);
    expected_status.push_back(status);
  endtask

  task automatic shadow_register(input logic [2:0] idx, input logic [7:0] data);
    case (idx)
      REG_MOTOR_KIND:  kind_q        = data[1:0];
      REG_SPEED_MODE:  speed_q       = data[1:0];
      REG_HOLD_LENGTH: hold_len_q    = data;
      REG_SLOW_RELOAD: slow_reload_q = data;
      REG_FAST_RELOAD: fast_reload_q = data;
      default: ;
    endcase
  endtask

  // Compare one status word from the block with the oldest expected word.
  task automatic check_status();
    motor_status_t want;
    if (expected_status.size() == 0) begin
      $display("%0t: unexpected status word coils=%h position=%h at_target=%b", $time,
               res_bus.coil_pattern, res_bus.position_now, res_bus.at_target);
      fail_count++;
      return;
    end
    want = expected_status.pop_front();
    words_checked++;
    if (res_bus.coil_pattern !== want.coils) begin
      $display("%0t: coil_pattern expected %h actual %h", $time, want.coils,
               res_bus.coil_pattern);
      fail_count++;
    end
    if (res_bus.position_now !== want.position) begin
      $display("%0t: position_now expected %h actual %h", $time, want.position,
               res_bus.position_now);
      fail_count++;
    end
    if (res_bus.at_target !== want.at_target) begin
      $display("%0t: at_target expected %b actual %b", $time, want.at_target,
               res_bus.at_target);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset defaults and the bus monitor
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All monitoring happens at the rising edge, where every handshake signal still holds
  // its value from before the edge. The status word is checked before the new command is
  // predicted, so a word leaving at the same edge is matched against older commands only.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        shadow_register(cfg_bus.reg_index, cfg_bus.wdata);
      end
      if (res_bus.valid && res_bus.ready) begin
        check_status();
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        words_sent++;
        predict_status(cmd_bus.opcode, cmd_bus.position_value);
      end
    end
  end

  // Status receiver: after every accepted word it stalls for a freshly drawn number of
  // cycles, so stalls land on every phase of the block's work.
  initial begin
    int stall_left;
    stall_left    = 0;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) begin
        stall_left = pick_gap();
        res_bus.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= (stall_left == 0);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog, sized well above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one command word. Valid stays high after the handshake so that a word with no
  // gap follows at once; it drops when the next word draws a gap or when sending stops.
  task automatic send_command(input logic [2:0] op, input logic [15:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.opcode         <= op;
    cmd_bus.position_value <= value;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  // Stop sending and wait until every expected status word has been checked. Each
  // command yields exactly one word, so an empty queue means the block is idle.
  task automatic wait_until_settled();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_status.size() != 0);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  // Write all five registers while the block is idle. The two-bit registers get random
  // upper data bits, which the block must ignore.
  task automatic configure(input logic [1:0] kind, input logic [1:0] speed,
                           input logic [7:0] hold, input logic [7:0] slow,
                           input logic [7:0] fast);
    wait_until_settled();
    write_register(REG_MOTOR_KIND, {6'($urandom), kind});
    write_register(REG_SPEED_MODE, {6'($urandom), speed});
    write_register(REG_HOLD_LENGTH, hold);
    write_register(REG_SLOW_RELOAD, slow);
    write_register(REG_FAST_RELOAD, fast);
    cfg_bus.valid <= 1'b0;
    settings_applied++;
  endtask

  // Mostly ticks and short moves around the current position, so the channel walks
  // through holds, steps and coil-off periods; the rest is stops, rearms, jumps across
  // the whole range and spare opcodes.
  task automatic run_motion_mix(input int count);
    int          pick;
    logic [15:0] near;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      near = cur_pos + 16'($urandom_range(0, 40)) - 16'd20;
      if (pick < 62) begin
        send_command(OP_TICK, 16'($urandom));
      end else if (pick < 74) begin
        send_command(OP_SET_TARGET, near);
      end else if (pick < 77) begin
        send_command(OP_SET_TARGET, 16'($urandom));
      end else if (pick < 81) begin
        send_command(OP_SET_POS, 16'($urandom));
      end else if (pick < 85) begin
        send_command(OP_SET_POS, near);
      end else if (pick < 91) begin
        send_command(OP_STOP, 16'($urandom));
      end else if (pick < 96) begin
        send_command(OP_REARM_HOLD, 16'($urandom));
      end else begin
        send_command(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 16'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults, position extremes, wrap in both directions, stop in mid move,
  // rearm and the spare opcodes.
  task automatic test_directed_edges();
    // Default registers: a one-step move starts a twenty-period hold.
    send_command(OP_TICK, 16'h0000);
    send_command(OP_SET_TARGET, 16'h0001);
    send_command(OP_TICK, 16'hFFFF);
    send_command(OP_STOP, 16'h0000);
    configure(KIND_GAS_VALVE, SPEED_EVERY, 8'd1, 8'd29, 8'd2);
    send_command(OP_TICK, 16'h0000);
    send_command(OP_TICK, 16'h0000);
    send_command(OP_TICK, 16'h0000);
    // From the most negative to the most positive position is one step back.
    send_command(OP_SET_POS, 16'h8000);
    send_command(OP_SET_TARGET, 16'h7FFF);
    repeat (4) send_command(OP_TICK, 16'h0000);
    // And one step forward wraps the other way.
    send_command(OP_SET_TARGET, 16'h8000);
    repeat (3) send_command(OP_TICK, 16'h0000);
    send_command(OP_SET_POS, 16'h0000);
    send_command(OP_SET_TARGET, 16'hFFFF);
    repeat (3) send_command(OP_TICK, 16'h0000);
    // Stop in mid move, then rearm the holds without a move.
    send_command(OP_SET_TARGET, 16'h0005);
    repeat (3) send_command(OP_TICK, 16'h0000);
    send_command(OP_STOP, 16'h7FFF);
    send_command(OP_TICK, 16'h0000);
    send_command(OP_REARM_HOLD, 16'h8000);
    send_command(OP_TICK, 16'h0000);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_command(3'(op), (op == OP_SPARE_FIRST) ? 16'h5555 : 16'hAAAA);
    end
  endtask

  task automatic test_gas_valve_every_tick();
    configure(KIND_GAS_VALVE, SPEED_EVERY, 8'd0, 8'd29, 8'd2);
    run_motion_mix(170);
  endtask

  task automatic test_door_fast_no_reload();
    configure(KIND_ICE_DOOR, SPEED_FAST, 8'd1, 8'd255, 8'd0);
    run_motion_mix(170);
  endtask

  task automatic test_hot_slow_prescale();
    configure(KIND_HOT, SPEED_SLOW, 8'd2, 8'd3, 8'd255);
    run_motion_mix(170);
  endtask

  task automatic test_fast_reload_max();
    configure(KIND_GAS_VALVE, SPEED_FAST, 8'd0, 8'd0, 8'd255);
    run_motion_mix(170);
  endtask

  task automatic test_slow_reload_zero();
    configure(KIND_ICE_DOOR, SPEED_SLOW, 8'd3, 8'd0, 8'd7);
    run_motion_mix(170);
  endtask

  // Motor kind without a decoder and the spare speed mode: state moves, coils freeze.
  task automatic test_spare_codes();
    configure(KIND_NO_DECODER, SPEED_SPARE, 8'd4, 8'd1, 8'd1);
    run_motion_mix(170);
  endtask

  // The longest hold: a short move only begins after 255 periods of start hold.
  task automatic test_long_hold();
    configure(KIND_ICE_DOOR, SPEED_EVERY, 8'd255, 8'd255, 8'd255);
    send_command(OP_SET_TARGET, cur_pos + 16'd3);
    repeat (268) send_command(OP_TICK, 16'($urandom));
    send_command(OP_STOP, 16'h0000);
    repeat (4) send_command(OP_TICK, 16'h0000);
  endtask

  // No idling on either side, with one pause in the middle until the block drains.
  task automatic test_back_to_back();
    configure(KIND_HOT, SPEED_FAST, 8'd1, 8'd5, 8'd1);
    no_gaps = 1'b1;
    run_motion_mix(85);
    wait_until_settled();
    run_motion_mix(85);
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Register defaults and cleared motion state, as after reset.
    kind_q        = KIND_GAS_VALVE;
    speed_q       = SPEED_EVERY;
    hold_len_q    = HOLD_LENGTH_RST;
    slow_reload_q = SLOW_RELOAD_RST;
    fast_reload_q = FAST_RELOAD_RST;
    tgt_pos       = '0;
    cur_pos       = '0;
    steps_left    = '0;
    prescale      = '0;
    start_hold    = '0;
    stop_hold     = '0;
    phase         = '0;
    coils         = '0;

    fail_count       = 0;
    words_sent       = 0;
    words_checked    = 0;
    settings_applied = 0;
    no_gaps          = 1'b0;

    cmd_bus.valid          = 1'b0;
    cmd_bus.opcode         = OP_TICK;
    cmd_bus.position_value = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.reg_index      = REG_MOTOR_KIND;
    cfg_bus.wdata          = '0;

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_gas_valve_every_tick();
    test_door_fast_no_reload();
    test_hot_slow_prescale();
    test_fast_reload_max();
    test_slow_reload_zero();
    test_spare_codes();
    test_long_hold();
    test_back_to_back();

    // Drain, then give the registered result path a little slack for stray words.
    wait_until_settled();
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d command words and %0d status words under %0d register",
             words_sent, words_checked, settings_applied);
    $display("settings: all motor kinds, all speed modes, hold and reload extremes, wraps.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
